### rtl/core/tlvp_pkg.sv
// Shared types, codes and helpers for the TLV reply field parser.
`timescale 1ns / 1ps

package tlvp_pkg;

  localparam int unsigned TYPE_W   = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SHIFT_W  = 64;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [LEN_W-1:0] ID_LEN    = LEN_W'(4);
  localparam logic [LEN_W-1:0] STAMP_LEN = LEN_W'(8);

  typedef enum logic [2:0] {
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_VALUE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_ID,
    KIND_SEQ,
    KIND_STAMP,
    KIND_VER
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_TYPE    = 8'd0,
    CFG_SEQ_TYPE   = 8'd1,
    CFG_STAMP_TYPE = 8'd2,
    CFG_VER_TYPE   = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TYPE_W-1:0] id_code;
    logic [TYPE_W-1:0] seq_code;
    logic [TYPE_W-1:0] stamp_code;
    logic [TYPE_W-1:0] ver_code;
  } codes_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } word_t;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] sender_id;
    logic [VAL_W-1:0] sequence_res;
    logic [VAL_W-1:0] stamp_seconds;
    logic [VAL_W-1:0] stamp_microseconds;
    logic             have_id;
    logic             have_sequence;
    logic             have_stamp;
  } result_t;

  // First match wins: id, sequence, stamp, version.
  function automatic kind_t kind_of(logic [TYPE_W-1:0] t, codes_t c);
    kind_t k;
    if (t == c.id_code) begin
      k = KIND_ID;
    end else if (t == c.seq_code) begin
      k = KIND_SEQ;
    end else if (t == c.stamp_code) begin
      k = KIND_STAMP;
    end else if (t == c.ver_code) begin
      k = KIND_VER;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

### rtl/core/tlvp_in_if.sv
// Byte input channel: valid/ready with one payload byte and an end marker.
`timescale 1ns / 1ps

interface tlvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/tlvp_out_if.sv
// Result channel: valid/ready with packet status, decoded values and flags.
`timescale 1ns / 1ps

interface tlvp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] sender_id;
  logic [31:0] sequence_res;
  logic [31:0] stamp_seconds;
  logic [31:0] stamp_microseconds;
  logic        have_id;
  logic        have_sequence;
  logic        have_stamp;

  modport source (output valid, output status, output sender_id, output sequence_res,
                  output stamp_seconds, output stamp_microseconds, output have_id,
                  output have_sequence, output have_stamp, input ready);
  modport sink   (input valid, input status, input sender_id, input sequence_res,
                  input stamp_seconds, input stamp_microseconds, input have_id,
                  input have_sequence, input have_stamp, output ready);
endinterface

### rtl/core/tlvp_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
`timescale 1ns / 1ps

interface tlvp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/tlv_reply_field_parser_top.sv
// Top level of the TLV reply field parser.
`timescale 1ns / 1ps

// Takes one payload byte per cycle and parses it as type-length-value records
// (16-bit big-endian type and length). Sender id, sequence number and timestamp
// are captured when their record types match the programmed codes; a result
// word is issued only for the byte marked last, carrying status, the value
// registers and the per-packet presence flags. Throughput is one byte per
// cycle; a last byte waits in the input register only while the previous
// result word has not been taken. The result word is registered: the input
// register takes the last byte, then the result register takes the parse
// outcome when that byte is taken from the input register. Type codes are
// written through cfg (index 0..3); write them only while no packet is in
// flight. Indexes above 3 are dropped.
module tlv_reply_field_parser_top (
  input  logic      clk,
  input  logic      rst_n,
  tlvp_in_if.sink   in_ch,
  tlvp_out_if.source out_ch,
  tlvp_cfg_if.sink  cfg_ch
);

  tlvp_pkg::codes_t  codes;
  tlvp_pkg::word_t   in_word;
  tlvp_pkg::word_t   word;
  tlvp_pkg::result_t res;
  logic              word_valid;
  logic              word_take;
  logic              res_valid;

  assign in_word.data_byte = in_ch.data_byte;
  assign in_word.last_byte = in_ch.last_byte;

  tlvp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .wr_ready (cfg_ch.ready),
    .codes    (codes)
  );

  tlvp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_word    (in_word),
    .in_ready   (in_ch.ready),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take)
  );

  tlvp_parser u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .codes      (codes),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (out_ch.ready)
  );

  assign out_ch.valid              = res_valid;
  assign out_ch.status             = res.status;
  assign out_ch.sender_id          = res.sender_id;
  assign out_ch.sequence_res       = res.sequence_res;
  assign out_ch.stamp_seconds      = res.stamp_seconds;
  assign out_ch.stamp_microseconds = res.stamp_microseconds;
  assign out_ch.have_id            = res.have_id;
  assign out_ch.have_sequence      = res.have_sequence;
  assign out_ch.have_stamp         = res.have_stamp;

endmodule

### rtl/core/tlvp_cfg_regs.sv
// Type code registers written through the configuration channel.
`timescale 1ns / 1ps

module tlvp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_valid,
  input  logic [tlvp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [tlvp_pkg::TYPE_W-1:0]    wr_data,
  output logic                           wr_ready,
  output tlvp_pkg::codes_t               codes
);

  tlvp_pkg::codes_t codes_r, codes_nxt;

  assign wr_ready = 1'b1;
  assign codes    = codes_r;

  always_comb begin
    codes_nxt = codes_r;
    if (wr_valid) begin
      unique case (wr_index)
        tlvp_pkg::CFG_ID_TYPE:    codes_nxt.id_code    = wr_data;
        tlvp_pkg::CFG_SEQ_TYPE:   codes_nxt.seq_code   = wr_data;
        tlvp_pkg::CFG_STAMP_TYPE: codes_nxt.stamp_code = wr_data;
        tlvp_pkg::CFG_VER_TYPE:   codes_nxt.ver_code   = wr_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.id_code    <= tlvp_pkg::TYPE_W'(1);
      codes_r.seq_code   <= tlvp_pkg::TYPE_W'(2);
      codes_r.stamp_code <= tlvp_pkg::TYPE_W'(3);
      codes_r.ver_code   <= tlvp_pkg::TYPE_W'(5);
    end else begin
      codes_r <= codes_nxt;
    end
  end

endmodule

### rtl/core/tlvp_in_reg.sv
// Input register stage holding one accepted byte word.
`timescale 1ns / 1ps

module tlvp_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  tlvp_pkg::word_t in_word,
  output logic            in_ready,
  output logic            word_valid,
  output tlvp_pkg::word_t word,
  input  logic            word_take
);

  logic            valid_r, valid_nxt;
  tlvp_pkg::word_t word_r;

  assign in_ready   = !valid_r || word_take;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= in_word;
    end
  end

endmodule

### rtl/core/tlvp_parser.sv
// Record parse state, value registers and the result register.
`timescale 1ns / 1ps

module tlvp_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tlvp_pkg::codes_t        codes,
  input  logic                    word_valid,
  input  tlvp_pkg::word_t         word,
  output logic                    word_take,
  output logic                    res_valid,
  output tlvp_pkg::result_t       res,
  input  logic                    res_ready
);

  localparam int unsigned VW = tlvp_pkg::VAL_W;

  tlvp_pkg::phase_t phase_r, phase_nxt, phase_step;
  logic [tlvp_pkg::TYPE_W-1:0]  rtype_r, rtype_nxt;
  logic [tlvp_pkg::LEN_W-1:0]   left_r, left_nxt, left_dec, len_full;
  logic [tlvp_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic                         err_r, err_nxt, err_step;
  logic [2:0]                   seen_r, seen_nxt, seen_step;
  logic [VW-1:0]                id_r, id_nxt;
  logic [VW-1:0]                seq_r, seq_nxt;
  logic [VW-1:0]                sec_r, sec_nxt;
  logic [VW-1:0]                usec_r, usec_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tlvp_pkg::result_t            out_r, out_nxt;
  tlvp_pkg::kind_t              kind;
  logic                         hdr_bad;
  logic                         out_free;
  logic                         fire;
  logic                         is_last;

  assign out_free  = !out_valid_r || res_ready;
  assign is_last   = word.last_byte;
  assign word_take = word_valid && (!is_last || out_free);
  assign fire      = word_take;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  assign kind     = tlvp_pkg::kind_of(rtype_r, codes);
  assign len_full = {left_r[15:8], word.data_byte};
  assign left_dec = left_r - tlvp_pkg::LEN_W'(1);

  always_comb begin
    case (kind)
      tlvp_pkg::KIND_ID,
      tlvp_pkg::KIND_SEQ:   hdr_bad = (len_full != tlvp_pkg::ID_LEN);
      tlvp_pkg::KIND_STAMP: hdr_bad = (len_full != tlvp_pkg::STAMP_LEN);
      tlvp_pkg::KIND_VER:   hdr_bad = (len_full == '0);
      default:              hdr_bad = 1'b0;
    endcase
  end

  // Next phase
  always_comb begin
    phase_step = phase_r;
    if (!err_r) begin
      unique case (phase_r)
        tlvp_pkg::PH_TYPE_HI: phase_step = tlvp_pkg::PH_TYPE_LO;
        tlvp_pkg::PH_TYPE_LO: phase_step = tlvp_pkg::PH_LEN_HI;
        tlvp_pkg::PH_LEN_HI:  phase_step = tlvp_pkg::PH_LEN_LO;
        tlvp_pkg::PH_LEN_LO: begin
          if (hdr_bad) begin
            phase_step = tlvp_pkg::PH_LEN_LO;
          end else if (len_full == '0) begin
            phase_step = tlvp_pkg::PH_TYPE_HI;
          end else begin
            phase_step = tlvp_pkg::PH_VALUE;
          end
        end
        tlvp_pkg::PH_VALUE: begin
          if (left_dec == '0) begin
            phase_step = tlvp_pkg::PH_TYPE_HI;
          end
        end
        default: phase_step = tlvp_pkg::PH_TYPE_HI;
      endcase
    end
    phase_nxt = phase_r;
    if (fire) begin
      phase_nxt = is_last ? tlvp_pkg::PH_TYPE_HI : phase_step;
    end
  end

  // Datapath updates for the byte in the input register
  always_comb begin
    rtype_nxt = rtype_r;
    left_nxt  = left_r;
    shift_nxt = shift_r;
    err_step  = err_r;
    seen_step = seen_r;
    id_nxt    = id_r;
    seq_nxt   = seq_r;
    sec_nxt   = sec_r;
    usec_nxt  = usec_r;
    if (fire && !err_r) begin
      unique case (phase_r)
        tlvp_pkg::PH_TYPE_HI: rtype_nxt = {word.data_byte, 8'h00};
        tlvp_pkg::PH_TYPE_LO: rtype_nxt = {rtype_r[15:8], word.data_byte};
        tlvp_pkg::PH_LEN_HI:  left_nxt  = {word.data_byte, 8'h00};
        tlvp_pkg::PH_LEN_LO: begin
          if (hdr_bad) begin
            err_step = 1'b1;
          end else begin
            left_nxt  = len_full;
            shift_nxt = '0;
          end
        end
        tlvp_pkg::PH_VALUE: begin
          shift_nxt = {shift_r[tlvp_pkg::SHIFT_W-9:0], word.data_byte};
          left_nxt  = left_dec;
          if (left_dec == '0) begin
            case (kind)
              tlvp_pkg::KIND_ID: begin
                id_nxt       = shift_nxt[VW-1:0];
                seen_step[0] = 1'b1;
              end
              tlvp_pkg::KIND_SEQ: begin
                seq_nxt      = shift_nxt[VW-1:0];
                seen_step[1] = 1'b1;
              end
              tlvp_pkg::KIND_STAMP: begin
                sec_nxt      = shift_nxt[2*VW-1:VW];
                usec_nxt     = shift_nxt[VW-1:0];
                seen_step[2] = 1'b1;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end

    out_nxt.status             = err_step || (phase_step != tlvp_pkg::PH_TYPE_HI);
    out_nxt.sender_id          = id_nxt;
    out_nxt.sequence_res       = seq_nxt;
    out_nxt.stamp_seconds      = sec_nxt;
    out_nxt.stamp_microseconds = usec_nxt;
    out_nxt.have_id            = seen_step[0];
    out_nxt.have_sequence      = seen_step[1];
    out_nxt.have_stamp         = seen_step[2];

    err_nxt  = err_step;
    seen_nxt = seen_step;
    // end of packet: per-packet state clears, values stay
    if (fire && is_last) begin
      rtype_nxt = '0;
      left_nxt  = '0;
      shift_nxt = '0;
      err_nxt   = 1'b0;
      seen_nxt  = '0;
    end

    out_valid_nxt = out_valid_r && !res_ready;
    if (fire && is_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tlvp_pkg::PH_TYPE_HI;
      rtype_r     <= '0;
      left_r      <= '0;
      shift_r     <= '0;
      err_r       <= 1'b0;
      seen_r      <= '0;
      id_r        <= '0;
      seq_r       <= '0;
      sec_r       <= '0;
      usec_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      rtype_r     <= rtype_nxt;
      left_r      <= left_nxt;
      shift_r     <= shift_nxt;
      err_r       <= err_nxt;
      seen_r      <= seen_nxt;
      id_r        <= id_nxt;
      seq_r       <= seq_nxt;
      sec_r       <= sec_nxt;
      usec_r      <= usec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_last) begin
      out_r <= out_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_last |=> (phase_r == tlvp_pkg::PH_TYPE_HI) && !err_r && (seen_r == '0))
    else $error("parse state not cleared after last byte");

  a_flags_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !is_last |=> ((seen_r & $past(seen_r)) == $past(seen_r)))
    else $error("presence flag dropped inside a packet");

  a_error_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(fire && is_last) |=> $stable(id_r) && $stable(seq_r) && $stable(seen_r))
    else $error("value changed after packet error");

  a_value_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tlvp_pkg::PH_VALUE |-> left_r != '0)
    else $error("value phase with no bytes left");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_last |=> out_valid_r)
    else $error("last byte produced no result");

endmodule

### tb/tb.sv
// Self-checking testbench for the TLV reply field parser: packet stimulus, parser model, scoreboard.
`timescale 1ns / 1ps

module tb;

  localparam int          WATCHDOG_LIMIT = 400;
  localparam int          DRAIN_CYCLES   = 6;
  localparam int          PHASE_BYTES    = 60;
  localparam int          PHASE_PACKETS  = 3;
  localparam logic [7:0]  CFG_IDX_UNUSED = 8'd4;
  localparam logic [7:0]  CFG_IDX_TOP    = 8'hFF;

  typedef struct packed {
    logic [7:0]        b;
    logic              is_last;
    logic              typed;
    tlvp_pkg::result_t r;
  } dir_row_t;

  // hand-written results for the directed packets
  localparam tlvp_pkg::result_t R_CUT_HEADER = '{1'b1, 32'h0, 32'h0, 32'h0, 32'h0,
                                                 1'b0, 1'b0, 1'b0};
  localparam tlvp_pkg::result_t R_EMPTY_OK   = '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0,
                                                 1'b0, 1'b0, 1'b0};
  localparam tlvp_pkg::result_t R_ID_ONES    = '{1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                                                 1'b1, 1'b0, 1'b0};
  localparam tlvp_pkg::result_t R_BAD_KEEP   = '{1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                                                 1'b0, 1'b0, 1'b0};
  localparam tlvp_pkg::result_t R_NONE       = '0;

  localparam dir_row_t DIR_TAB [27] = '{
    // lone byte: packet ends inside the header
    '{8'h00, 1'b1, 1'b1, R_CUT_HEADER},
    // unknown type 0xFFFF, zero length: skipped, well formed
    '{8'hFF, 1'b0, 1'b0, R_NONE}, '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b1, 1'b1, R_EMPTY_OK},
    // sender id of all ones
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h01, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h04, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE}, '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE}, '{8'hFF, 1'b1, 1'b1, R_ID_ONES},
    // empty version string: malformed, id value kept, flags cleared
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h05, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h00, 1'b1, 1'b1, R_BAD_KEEP},
    // timestamp of length 4, trailing byte ignored after the error
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h03, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h04, 1'b0, 1'b0, R_NONE},
    '{8'hAA, 1'b1, 1'b1, R_BAD_KEEP},
    // sequence cut inside its value
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h02, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b0, 1'b0, R_NONE}, '{8'h04, 1'b0, 1'b0, R_NONE},
    '{8'h12, 1'b1, 1'b0, R_NONE}
  };

  logic clk;
  logic rst_n;

  tlvp_in_if  in_ch();
  tlvp_out_if out_ch();
  tlvp_cfg_if cfg_ch();

  tlv_reply_field_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // parser model state
  tlvp_pkg::codes_t  codes;
  tlvp_pkg::phase_t  p_phase;
  logic [15:0]       p_type;
  logic [15:0]       p_left;
  logic [63:0]       p_shift;
  logic              p_err;
  logic [2:0]        p_flags;
  logic [31:0]       p_id;
  logic [31:0]       p_seq;
  logic [31:0]       p_sec;
  logic [31:0]       p_usec;

  tlvp_pkg::result_t pending_results[$];
  logic [7:0]        packet_bytes[$];

  int          errors;
  int          idle_cycles;
  int          n_bytes;
  int          n_packets;
  int          n_malformed;
  int          n_settings;
  int          n_have_id;
  int          n_have_seq;
  int          n_have_stamp;
  bit          tx_burst;
  bit          rx_burst;

  always #5 clk = ~clk;

  function automatic tlvp_pkg::kind_t record_kind(logic [15:0] t);
    tlvp_pkg::kind_t k;
    k = tlvp_pkg::KIND_OTHER;
    if (t == codes.ver_code) k = tlvp_pkg::KIND_VER;
    if (t == codes.stamp_code) k = tlvp_pkg::KIND_STAMP;
    if (t == codes.seq_code) k = tlvp_pkg::KIND_SEQ;
    if (t == codes.id_code) k = tlvp_pkg::KIND_ID;
    return k;
  endfunction

  task automatic clear_packet_state();
    p_phase = tlvp_pkg::PH_TYPE_HI;
    p_type  = '0;
    p_left  = '0;
    p_shift = '0;
    p_err   = 1'b0;
    p_flags = '0;
  endtask

  // one accepted byte through the parser model; fin set when it ends a packet
  task automatic parse_byte(input logic [7:0] b, input logic is_last,
                            output bit fin, output tlvp_pkg::result_t r);
    logic [15:0]     len;
    tlvp_pkg::kind_t k;
    fin = 1'b0;
    r   = '0;
    if (!p_err) begin
      case (p_phase)
        tlvp_pkg::PH_TYPE_HI: begin
          p_type  = {b, 8'h00};
          p_phase = tlvp_pkg::PH_TYPE_LO;
        end
        tlvp_pkg::PH_TYPE_LO: begin
          p_type[7:0] = b;
          p_phase     = tlvp_pkg::PH_LEN_HI;
        end
        tlvp_pkg::PH_LEN_HI: begin
          p_left  = {b, 8'h00};
          p_phase = tlvp_pkg::PH_LEN_LO;
        end
        tlvp_pkg::PH_LEN_LO: begin
          len = {p_left[15:8], b};
          k   = record_kind(p_type);
          if (((k == tlvp_pkg::KIND_ID || k == tlvp_pkg::KIND_SEQ) &&
               len != tlvp_pkg::ID_LEN) ||
              (k == tlvp_pkg::KIND_STAMP && len != tlvp_pkg::STAMP_LEN) ||
              (k == tlvp_pkg::KIND_VER && len == '0)) begin
            p_err = 1'b1;
          end else begin
            p_left  = len;
            p_shift = '0;
            p_phase = (len == '0) ? tlvp_pkg::PH_TYPE_HI : tlvp_pkg::PH_VALUE;
          end
        end
        tlvp_pkg::PH_VALUE: begin
          p_shift = {p_shift[55:0], b};
          p_left  = p_left - 16'd1;
          if (p_left == '0) begin
            // type is looked up again at the final value byte
            case (record_kind(p_type))
              tlvp_pkg::KIND_ID: begin
                p_id       = p_shift[31:0];
                p_flags[0] = 1'b1;
              end
              tlvp_pkg::KIND_SEQ: begin
                p_seq      = p_shift[31:0];
                p_flags[1] = 1'b1;
              end
              tlvp_pkg::KIND_STAMP: begin
                p_sec      = p_shift[63:32];
                p_usec     = p_shift[31:0];
                p_flags[2] = 1'b1;
              end
              default: ;
            endcase
            p_phase = tlvp_pkg::PH_TYPE_HI;
          end
        end
        default: p_phase = tlvp_pkg::PH_TYPE_HI;
      endcase
    end
    if (is_last) begin
      fin = 1'b1;
      r = '{p_err || p_phase != tlvp_pkg::PH_TYPE_HI, p_id, p_seq, p_sec, p_usec,
            p_flags[0], p_flags[1], p_flags[2]};
      clear_packet_state();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // present one byte; valid is lowered only when a gap precedes it
  task automatic feed_byte(input logic [7:0] b, input logic is_last,
                           input bit typed, input tlvp_pkg::result_t hand);
    int                gap;
    bit                fin;
    tlvp_pkg::result_t r;
    gap = tx_burst ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    n_bytes++;
    parse_byte(b, is_last, fin, r);
    if (fin) begin
      if (typed) r = hand;
      pending_results.push_back(r);
      n_packets++;
      if (r.status) n_malformed++;
      n_have_id    += int'(r.have_id);
      n_have_seq   += int'(r.have_sequence);
      n_have_stamp += int'(r.have_stamp);
    end
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      tlvp_pkg::CFG_ID_TYPE:    codes.id_code    = val;
      tlvp_pkg::CFG_SEQ_TYPE:   codes.seq_code   = val;
      tlvp_pkg::CFG_STAMP_TYPE: codes.stamp_code = val;
      tlvp_pkg::CFG_VER_TYPE:   codes.ver_code   = val;
      default: ;
    endcase
  endtask

  // wait for the parser to drain, then reprogram all four type codes
  task automatic program_codes(input logic [15:0] id_c, input logic [15:0] seq_c,
                               input logic [15:0] stamp_c, input logic [15:0] ver_c,
                               input logic [7:0] junk_idx);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(tlvp_pkg::CFG_VER_TYPE, ver_c);
    write_reg(junk_idx, 16'($urandom));
    write_reg(tlvp_pkg::CFG_ID_TYPE, id_c);
    write_reg(tlvp_pkg::CFG_STAMP_TYPE, stamp_c);
    write_reg(tlvp_pkg::CFG_SEQ_TYPE, seq_c);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // a packet of records, mostly well formed, some with bad lengths, cut short, or noise
  task automatic build_packet();
    int              n_rec;
    int              n_val;
    logic [15:0]     t;
    logic [15:0]     len;
    tlvp_pkg::kind_t k;
    packet_bytes.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) packet_bytes.push_back(8'($urandom));
    end else begin
      n_rec = $urandom_range(0, 4);
      repeat (n_rec) begin
        case ($urandom_range(5))
          0: t = codes.id_code;
          1: t = codes.seq_code;
          2: t = codes.stamp_code;
          3: t = codes.ver_code;
          default: t = 16'($urandom);
        endcase
        k = record_kind(t);
        case (k)
          tlvp_pkg::KIND_ID, tlvp_pkg::KIND_SEQ: len = tlvp_pkg::ID_LEN;
          tlvp_pkg::KIND_STAMP:                  len = tlvp_pkg::STAMP_LEN;
          tlvp_pkg::KIND_VER:                    len = 16'($urandom_range(1, 6));
          default:                               len = 16'($urandom_range(0, 6));
        endcase
        if ($urandom_range(7) == 0) begin
          len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
        end
        packet_bytes.push_back(t[15:8]);
        packet_bytes.push_back(t[7:0]);
        packet_bytes.push_back(len[15:8]);
        packet_bytes.push_back(len[7:0]);
        n_val = (len > 16'd12) ? 12 : int'(len);
        repeat (n_val) packet_bytes.push_back(8'($urandom));
      end
      if (packet_bytes.size() == 0) packet_bytes.push_back(8'($urandom));
      if (packet_bytes.size() > 1 && $urandom_range(5) == 0) begin
        packet_bytes = packet_bytes[0 : $urandom_range(0, packet_bytes.size() - 2)];
      end
    end
  endtask

  task automatic run_phase();
    int start_bytes;
    int start_packets;
    start_bytes   = n_bytes;
    start_packets = n_packets;
    while (n_bytes - start_bytes < PHASE_BYTES || n_packets - start_packets < PHASE_PACKETS) begin
      build_packet();
      tx_burst = ($urandom_range(3) == 0);
      foreach (packet_bytes[i]) begin
        feed_byte(packet_bytes[i], i == packet_bytes.size() - 1, 1'b0, R_NONE);
      end
    end
  endtask

  // result side: random back-pressure, with stretches of none
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    rx_burst = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // scoreboard
  always @(posedge clk) begin
    tlvp_pkg::result_t got;
    tlvp_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.sender_id, out_ch.sequence_res, out_ch.stamp_seconds,
              out_ch.stamp_microseconds, out_ch.have_id, out_ch.have_sequence,
              out_ch.have_stamp};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", got[63:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.sender_id !== want.sender_id)
          report_mismatch("sender_id", 64'(got.sender_id), 64'(want.sender_id));
        if (got.sequence_res !== want.sequence_res)
          report_mismatch("sequence_res", 64'(got.sequence_res), 64'(want.sequence_res));
        if (got.stamp_seconds !== want.stamp_seconds)
          report_mismatch("stamp_seconds", 64'(got.stamp_seconds), 64'(want.stamp_seconds));
        if (got.stamp_microseconds !== want.stamp_microseconds)
          report_mismatch("stamp_microseconds", 64'(got.stamp_microseconds),
                          64'(want.stamp_microseconds));
        if (got.have_id !== want.have_id)
          report_mismatch("have_id", 64'(got.have_id), 64'(want.have_id));
        if (got.have_sequence !== want.have_sequence)
          report_mismatch("have_sequence", 64'(got.have_sequence), 64'(want.have_sequence));
        if (got.have_stamp !== want.have_stamp)
          report_mismatch("have_stamp", 64'(got.have_stamp), 64'(want.have_stamp));
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    idle_cycles     = 0;
    errors          = 0;
    n_bytes         = 0;
    n_packets       = 0;
    n_malformed     = 0;
    n_settings      = 1;
    n_have_id       = 0;
    n_have_seq      = 0;
    n_have_stamp    = 0;
    tx_burst        = 1'b0;
    codes           = '{16'd1, 16'd2, 16'd3, 16'd5};
    p_id            = '0;
    p_seq           = '0;
    p_sec           = '0;
    p_usec          = '0;
    clear_packet_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) feed_byte(DIR_TAB[i].b, DIR_TAB[i].is_last, DIR_TAB[i].typed,
                                   DIR_TAB[i].r);
    run_phase();

    program_codes(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, CFG_IDX_UNUSED);
    run_phase();
    // every code equal: id takes precedence
    program_codes(16'h00AA, 16'h00AA, 16'h00AA, 16'h00AA, CFG_IDX_TOP);
    run_phase();
    // sequence shadows stamp and version
    program_codes(16'h4321, 16'h1234, 16'h1234, 16'h1234, CFG_IDX_UNUSED);
    run_phase();
    begin
      logic [15:0] shared;
      shared = 16'($urandom);
      program_codes(16'($urandom), 16'($urandom), shared, shared, CFG_IDX_TOP);
    end
    run_phase();
    program_codes(16'd1, 16'd2, 16'd3, 16'd5, CFG_IDX_UNUSED);
    run_phase();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes in %0d packets (%0d malformed) under %0d code settings.",
             n_bytes, n_packets, n_malformed, n_settings);
    $display("Records captured: id %0d, sequence %0d, timestamp %0d packets; %0d mismatches.",
             n_have_id, n_have_seq, n_have_stamp, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
